/* rtl/dkte_pkg.sv */
// ----------------------------------------------------------------------------
// dkte_pkg
// Shared types and constants for the detent knob target and error core.
// ----------------------------------------------------------------------------
package dkte_pkg;

  localparam int ANGLE_BITS_DEF  = 12;
  localparam int MAX_DETENTS_DEF = 256;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam int BASE_W = 12;
  localparam int HALF_W = 11;
  localparam int DET_W  = 9;
  localparam int DEAD_W = 10;
  localparam int VEL_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HALF   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DETENT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD   = 3'd4;

  localparam logic [HALF_W-1:0] HALF_RST   = 11'd512;
  localparam logic [DET_W-1:0]  DETENT_RST = 9'd8;
  localparam logic [DEAD_W-1:0] DEAD_RST   = 10'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV
  } state_t;

endpackage

/* rtl/dkte_serial_div.sv */
// ----------------------------------------------------------------------------
// dkte_serial_div
// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
// ----------------------------------------------------------------------------
module dkte_serial_div #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;
  logic             qbit;

  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, trial} - {2'b00, dvs_r};
    qbit    = ~diff[DVS_W+1];
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      dvs_nxt = divisor;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      rem_nxt = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], qbit};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

/* rtl/detent_knob_target_and_error_core.sv */
// ----------------------------------------------------------------------------
// detent_knob_target_and_error_core
// Detent snap, end-stop window, wrapped error with dead zone, low-pass velocity.
// Each angle passes through the prep state, the bit-serial multiplier and the bit-serial
// detent divider in turn, with the velocity divider running alongside; a new angle is
// accepted only after the previous result has been registered into the output.
// Reset: synchronous; registers return to defaults, velocity and history clear.
// ----------------------------------------------------------------------------
module detent_knob_target_and_error_core #(
  parameter int ANGLE_BITS  = dkte_pkg::ANGLE_BITS_DEF,
  parameter int MAX_DETENTS = dkte_pkg::MAX_DETENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dkte_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dkte_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // angle
  input  logic [((ANGLE_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // target_angle, target_err, dz_err, velocity
  output logic [((3*ANGLE_BITS+18+7)/8)*8-1:0] out_tdata,
  // in_window
  output logic                              out_tuser
);

  localparam int AB     = ANGLE_BITS;
  localparam int TURN   = 2 ** ANGLE_BITS;
  localparam int HALF   = TURN / 2;
  localparam int NW     = $clog2(MAX_DETENTS + 1);
  localparam int NCW    = (NW > dkte_pkg::DET_W) ? NW : dkte_pkg::DET_W;
  localparam int PW     = ANGLE_BITS + NW;
  localparam int SD_W   = NW + ANGLE_BITS + 1;
  localparam int STEP_W = $clog2(NW + 1);
  localparam int ERR_W  = ANGLE_BITS + 1;
  localparam int WD_W   = ANGLE_BITS + 2;
  localparam int HW     = (ANGLE_BITS > dkte_pkg::HALF_W) ? ANGLE_BITS : dkte_pkg::HALF_W;
  localparam int BW     = (ANGLE_BITS > dkte_pkg::BASE_W) ? ANGLE_BITS : dkte_pkg::BASE_W;
  localparam int DZX_W  = (ANGLE_BITS + 2 > 12) ? ANGLE_BITS + 2 : 12;
  localparam int MAG_W  = (ANGLE_BITS + 4 > 19) ? ANGLE_BITS + 5 : 20;
  localparam int NUM_W  = MAG_W + 1;
  localparam int VW     = dkte_pkg::VEL_W;
  localparam int OUT_W  = ((3 * ANGLE_BITS + 18 + 7) / 8) * 8;

  function automatic logic signed [ERR_W-1:0] wrap_diff(input logic [AB-1:0] x,
                                                        input logic [AB-1:0] y);
    logic signed [WD_W-1:0] d;
    d = $signed({2'b00, x}) - $signed({2'b00, y});
    if (d > $signed(WD_W'(HALF))) d = d - $signed(WD_W'(TURN));
    else if (d < -$signed(WD_W'(HALF))) d = d + $signed(WD_W'(TURN));
    return d[ERR_W-1:0];
  endfunction

  function automatic logic [ERR_W-1:0] abs_err(input logic signed [ERR_W-1:0] e);
    logic signed [ERR_W-1:0] n;
    n = -e;
    return e[ERR_W-1] ? n : e;
  endfunction

  // configuration
  logic                          mode_r;
  logic [dkte_pkg::BASE_W-1:0]   base_r;
  logic [dkte_pkg::HALF_W-1:0]   half_r;
  logic [dkte_pkg::DET_W-1:0]    detent_r;
  logic [dkte_pkg::DEAD_W-1:0]   dead_r;

  dkte_pkg::state_t state_r, state_nxt;

  logic [AB-1:0]          a_r;
  logic [AB-1:0]          prev_r;
  logic                   have_prev_r;
  logic signed [VW-1:0]   vel_r;
  logic                   win_r;
  logic [AB-1:0]          edge_r;
  logic                   vneg_r;
  logic [PW-1:0]          acc_r, mcand_r;
  logic [NW-1:0]          mplier_r;
  logic [STEP_W-1:0]      step_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r;
  logic                   out_user_r;

  logic                   accept, fin;
  logic                   vdiv_start, sdiv_start;
  logic                   vdiv_busy, sdiv_busy;
  logic [MAG_W-1:0]       vdiv_q;
  logic [SD_W-1:0]        sdiv_q;

  // -------- shared config-derived values
  logic [NCW-1:0]         det_x;
  logic [NW-1:0]          n_eff;
  logic [BW-1:0]          base_x;
  logic [AB-1:0]          b;
  logic [HW-1:0]          h_x, h_cl;
  logic [AB-1:0]          h;

  always_comb begin
    det_x = NCW'(detent_r);
    if (detent_r == '0) n_eff = NW'(1);
    else if (det_x > NCW'(MAX_DETENTS)) n_eff = NW'(MAX_DETENTS);
    else n_eff = det_x[NW-1:0];
    base_x = BW'(base_r);
    b      = base_x[AB-1:0];
    h_x    = HW'(half_r);
    h_cl   = (h_x > HW'(HALF - 1)) ? HW'(HALF - 1) : h_x;
    h      = h_cl[AB-1:0];
  end

  // -------- window and edge selection (prep cycle)
  logic [AB-1:0]    up_a, lo_a;
  logic [ERR_W-1:0] dist_b, du, dl;
  logic             win_c;

  always_comb begin
    dist_b = abs_err(wrap_diff(a_r, b));
    win_c  = (dist_b <= {1'b0, h});
    up_a   = b + h;
    lo_a   = b - h;
    du     = abs_err(wrap_diff(up_a, a_r));
    dl     = abs_err(wrap_diff(lo_a, a_r));
  end

  // -------- velocity numerator (prep cycle)
  logic signed [ERR_W-1:0] dx;
  logic signed [NUM_W-1:0] vx, xx, num, num_neg;
  logic [MAG_W-1:0]        vmag;

  always_comb begin
    dx      = have_prev_r ? wrap_diff(a_r, prev_r) : '0;
    vx      = {{(NUM_W-VW){vel_r[VW-1]}}, vel_r};
    xx      = {{(NUM_W-ERR_W){dx[ERR_W-1]}}, dx};
    num     = (vx <<< 3) + vx + (xx <<< 4);
    num_neg = -num;
    vmag    = (num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0]) + MAG_W'(5);
  end

  // -------- detent index from product
  logic [PW-1:0]   idx_sum;
  logic [NW-1:0]   idx_raw, idx;
  logic [SD_W-1:0] sdiv_dvd;

  always_comb begin
    idx_sum  = acc_r + PW'(HALF);
    idx_raw  = idx_sum[PW-1:AB];
    idx      = (idx_raw == n_eff) ? '0 : idx_raw;
    sdiv_dvd = (SD_W'(idx) << (AB + 1)) + SD_W'(n_eff);
  end

  // -------- result assembly
  logic [AB-1:0]           tgt;
  logic signed [ERR_W-1:0] err;
  logic signed [DZX_W-1:0] err_x, dz_x, eff_x;
  logic signed [ERR_W-1:0] eff;
  logic [VW-1:0]           vel_new;
  logic [MAG_W-1:0]        vq_neg;

  always_comb begin
    tgt   = (mode_r && !win_r) ? edge_r : sdiv_q[AB-1:0];
    err   = wrap_diff(tgt, a_r);
    err_x = {{(DZX_W-ERR_W){err[ERR_W-1]}}, err};
    dz_x  = $signed(DZX_W'(dead_r));
    if ($signed({{(DZX_W-ERR_W){1'b0}}, abs_err(err)}) > dz_x) begin
      eff_x = err[ERR_W-1] ? err_x + dz_x : err_x - dz_x;
    end else begin
      eff_x = '0;
    end
    eff    = eff_x[ERR_W-1:0];
    vq_neg = -vdiv_q;
    if (!vneg_r) begin
      vel_new = (vdiv_q > MAG_W'(32767)) ? 16'h7FFF : vdiv_q[VW-1:0];
    end else begin
      vel_new = (vdiv_q > MAG_W'(32768)) ? 16'h8000 : vq_neg[VW-1:0];
    end
  end

  // -------- sequencer
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    vdiv_start = 1'b0;
    sdiv_start = 1'b0;
    fin        = 1'b0;
    case (state_r)
      dkte_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = dkte_pkg::ST_PREP;
      end
      dkte_pkg::ST_PREP: begin
        vdiv_start = 1'b1;
        state_nxt  = dkte_pkg::ST_MUL;
      end
      dkte_pkg::ST_MUL: begin
        if (step_r == '0) begin
          sdiv_start = 1'b1;
          state_nxt  = dkte_pkg::ST_DIV;
        end
      end
      dkte_pkg::ST_DIV: begin
        if (!sdiv_busy && !vdiv_busy && (!out_valid_r || out_tready)) begin
          fin       = 1'b1;
          state_nxt = dkte_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dkte_pkg::ST_IDLE;
    endcase
    accept        = in_tvalid && in_tready;
    out_valid_nxt = (out_valid_r && !out_tready) || fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dkte_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      vel_r       <= '0;
      mode_r      <= 1'b0;
      base_r      <= '0;
      half_r      <= dkte_pkg::HALF_RST;
      detent_r    <= dkte_pkg::DETENT_RST;
      dead_r      <= dkte_pkg::DEAD_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin) begin
        have_prev_r <= 1'b1;
        prev_r      <= a_r;
        vel_r       <= vel_new;
      end
      if (cfg_we) begin
        case (cfg_addr)
          dkte_pkg::REG_MODE:   mode_r   <= cfg_wdata[0];
          dkte_pkg::REG_BASE:   base_r   <= cfg_wdata[dkte_pkg::BASE_W-1:0];
          dkte_pkg::REG_HALF:   half_r   <= cfg_wdata[dkte_pkg::HALF_W-1:0];
          dkte_pkg::REG_DETENT: detent_r <= cfg_wdata[dkte_pkg::DET_W-1:0];
          dkte_pkg::REG_DEAD:   dead_r   <= cfg_wdata[dkte_pkg::DEAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // serial shift-add multiplier: angle * detent count
  always_ff @(posedge clk) begin
    if (accept) a_r <= in_tdata[AB-1:0];
    if (state_r == dkte_pkg::ST_PREP) begin
      win_r    <= win_c;
      edge_r   <= (du < dl) ? up_a : lo_a;
      vneg_r   <= num[NUM_W-1];
      acc_r    <= '0;
      mcand_r  <= PW'(a_r);
      mplier_r <= n_eff;
      step_r   <= STEP_W'(NW);
    end else if (state_r == dkte_pkg::ST_MUL && step_r != '0) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      step_r   <= step_r - STEP_W'(1);
    end
    if (fin) begin
      out_data_r <= OUT_W'({vel_new, eff, err, tgt});
      out_user_r <= !mode_r || win_r;
    end
  end

  dkte_serial_div #(
    .DVD_W (MAG_W),
    .DVS_W (4)
  ) u_vel_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (vdiv_start),
    .dividend (vmag),
    .divisor  (4'd10),
    .busy     (vdiv_busy),
    .quotient (vdiv_q)
  );

  // (2*idx*TURN + n) / (2*n)
  dkte_serial_div #(
    .DVD_W (SD_W),
    .DVS_W (NW + 1)
  ) u_snap_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sdiv_start),
    .dividend (sdiv_dvd),
    .divisor  ({n_eff, 1'b0}),
    .busy     (sdiv_busy),
    .quotient (sdiv_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
